// ----- hdl/rpsd_pkg.sv -----
// Shared types and constants of the run-length palette sprite decoder.
package rpsd_pkg;

   localparam int COORD_W      = 8;
   localparam int COLOR_W      = 16;
   localparam int RUN_BYTE_W   = 8;
   localparam int LEN_W        = 6;
   localparam int VALUE_W      = 3;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 64;
   localparam int BPP_W        = 2;
   localparam int MODE_W       = 3;
   localparam int QUEUE_DEPTH  = 2;
   localparam int WORD_ENTRIES = CSR_DATA_W / COLOR_W;

   localparam logic [BPP_W-1:0] BPP_THREE = 2'd3;

   localparam int MODE_FLIP_X = 0;
   localparam int MODE_FLIP_Y = 1;
   localparam int MODE_ALPHA  = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_ORIGIN_X      = 3'd0,
      REG_ORIGIN_Y      = 3'd1,
      REG_SPRITE_WIDTH  = 3'd2,
      REG_SPRITE_HEIGHT = 3'd3,
      REG_BITS_PER_PIX  = 3'd4,
      REG_MODE_FLAGS    = 3'd5,
      REG_PALETTE_LOW   = 3'd6,
      REG_PALETTE_HIGH  = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [COORD_W-1:0] origin_x;
      logic [COORD_W-1:0] origin_y;
      logic [COORD_W-1:0] sprite_width;
      logic [COORD_W-1:0] sprite_height;
      logic [BPP_W-1:0]   bits_per_pixel;
      logic [MODE_W-1:0]  mode_flags;
   } cfg_type;

   typedef struct packed {
      logic [LEN_W-1:0]   length;
      logic               transparent;
      logic [COLOR_W-1:0] color;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ----- hdl/rpsd_req_if.sv -----
// Run byte request channel.
interface rpsd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] run_byte;

   modport source (output valid, output run_byte, input ready);
   modport sink (input valid, input run_byte, output ready);
endinterface

// ----- hdl/rpsd_rsp_if.sv -----
// Pixel response channel.
interface rpsd_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  pixel_x;
   logic [7:0]  pixel_y;
   logic [15:0] pixel_color;
   logic        last_of_run;
   logic        end_of_image;

   modport source (output valid, output pixel_x, output pixel_y, output pixel_color,
                   output last_of_run, output end_of_image, input ready);
   modport sink (input valid, input pixel_x, input pixel_y, input pixel_color,
                 input last_of_run, input end_of_image, output ready);
endinterface

// ----- hdl/rpsd_csr_if.sv -----
// Configuration register write channel.
interface rpsd_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [63:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hdl/rpsd_csr.sv -----
// Configuration registers and palette storage.
module rpsd_csr #(
   parameter int PALETTE_ENTRIES = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   rpsd_csr_if.sink                csr_ch,
   output rpsd_pkg::cfg_type       cfg,
   output logic [rpsd_pkg::COLOR_W-1:0] palette [PALETTE_ENTRIES]
);
   import rpsd_pkg::*;

   cfg_type            cfg_ff;
   cfg_type            cfg_in;
   logic [COLOR_W-1:0] pal_ff [PALETTE_ENTRIES];
   logic               wr;

   assign csr_ch.ready = 1'b1;
   assign wr           = csr_ch.valid;
   assign cfg          = cfg_ff;
   assign palette      = pal_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (csr_index_type'(csr_ch.index))
            REG_ORIGIN_X:      cfg_in.origin_x = csr_ch.data[COORD_W-1:0];
            REG_ORIGIN_Y:      cfg_in.origin_y = csr_ch.data[COORD_W-1:0];
            REG_SPRITE_WIDTH:  cfg_in.sprite_width = csr_ch.data[COORD_W-1:0];
            REG_SPRITE_HEIGHT: cfg_in.sprite_height = csr_ch.data[COORD_W-1:0];
            REG_BITS_PER_PIX:  cfg_in.bits_per_pixel = csr_ch.data[BPP_W-1:0];
            REG_MODE_FLAGS:    cfg_in.mode_flags = csr_ch.data[MODE_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{origin_x: '0, origin_y: '0, sprite_width: '0, sprite_height: '0,
                     bits_per_pixel: 2'd2, mode_flags: '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   for (genvar e = 0; e < PALETTE_ENTRIES; e++) begin : g_pal
      localparam csr_index_type WORD_REG = (e < WORD_ENTRIES) ? REG_PALETTE_LOW
                                                               : REG_PALETTE_HIGH;
      localparam int SLOT = e % WORD_ENTRIES;
      always_ff @(posedge clock) begin
         if (reset) begin
            pal_ff[e] <= '0;
         end else if (wr && csr_index_type'(csr_ch.index) == WORD_REG) begin
            pal_ff[e] <= csr_ch.data[SLOT*COLOR_W +: COLOR_W];
         end
      end
   end

endmodule

// ----- hdl/rpsd_front.sv -----
// Front end: accepts run bytes, decodes them and drops zero-length runs and runs on an empty or off-screen sprite.
module rpsd_front #(
   parameter int PALETTE_ENTRIES = 8
) (
   rpsd_req_if.sink                     req_ch,
   input  rpsd_pkg::cfg_type            cfg,
   input  logic [rpsd_pkg::COLOR_W-1:0] palette [PALETTE_ENTRIES],
   input  rpsd_pkg::queue_status_type   q_status,
   output logic                         push,
   output rpsd_pkg::cmd_type            push_data
);
   import rpsd_pkg::*;

   logic               wide_value;
   logic [VALUE_W-1:0] value;
   logic [LEN_W-1:0]   length;
   logic               alpha;
   logic [VALUE_W-1:0] pal_idx;
   logic [COLOR_W-1:0] color;
   logic               overflow;
   logic               skip;

   assign req_ch.ready = !q_status.full;

   always_comb begin
      wide_value = (cfg.bits_per_pixel == BPP_THREE);
      if (wide_value) begin
         value  = req_ch.run_byte[7:5];
         length = {1'b0, req_ch.run_byte[4:0]};
      end else begin
         value  = {1'b0, req_ch.run_byte[7:6]};
         length = req_ch.run_byte[5:0];
      end
      alpha   = cfg.mode_flags[MODE_ALPHA];
      pal_idx = alpha ? value - 3'd1 : value;
      color   = '0;
      for (int e = 0; e < PALETTE_ENTRIES; e++) begin
         if (pal_idx == VALUE_W'(e)) begin
            color = palette[e];
         end
      end
      overflow = ({1'b0, cfg.origin_x} + {1'b0, cfg.sprite_width} > 9'd255)
              || ({1'b0, cfg.origin_y} + {1'b0, cfg.sprite_height} > 9'd255);
      skip = (length == '0) || (cfg.sprite_width == '0) || (cfg.sprite_height == '0)
          || overflow;
      push_data.length      = length;
      push_data.transparent = alpha && (value == '0);
      push_data.color       = color;
      push = req_ch.valid && req_ch.ready && !skip;
   end

endmodule

// ----- hdl/rpsd_queue.sv -----
// Short queue of decoded runs between the front and back ends.
module rpsd_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  rpsd_pkg::cmd_type          push_data,
   input  logic                       pop,
   output rpsd_pkg::cmd_type          pop_data,
   output rpsd_pkg::queue_status_type q_status
);
   import rpsd_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type          mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
      q_status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
      q_status.empty = (count_ff == '0);
      pop_data       = mem_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- hdl/rpsd_back.sv -----
// Back end: expands one run a pixel per cycle, unless the receiver stalls, into a registered response.
module rpsd_back (
   input  logic                       clock,
   input  logic                       reset,
   input  rpsd_pkg::cfg_type          cfg,
   input  rpsd_pkg::queue_status_type q_status,
   input  rpsd_pkg::cmd_type          pop_data,
   output logic                       pop,
   rpsd_rsp_if.source                 rsp_ch
);
   import rpsd_pkg::*;

   logic               busy_ff, busy_in;
   logic [COORD_W-1:0] col_ff, col_in;
   logic [COORD_W-1:0] row_ff, row_in;
   logic [LEN_W-1:0]   rem_ff, rem_in;
   cmd_type            cmd_ff;
   logic               out_valid_ff, out_valid_in;
   logic [COORD_W-1:0] out_x_ff, out_y_ff;
   logic [COLOR_W-1:0] out_color_ff;
   logic               out_last_ff, out_end_ff;

   logic               out_free;
   logic               step;
   logic               emit;
   logic               col_wrap;
   logic               done;
   logic               last;
   logic [COORD_W-1:0] px, py;

   always_comb begin
      out_free = !out_valid_ff || rsp_ch.ready;
      pop      = !busy_ff && !q_status.empty;
      step     = busy_ff && (cmd_ff.transparent || out_free);
      emit     = step && !cmd_ff.transparent;
      col_wrap = (col_ff + 8'd1 == cfg.sprite_width);
      done     = col_wrap && (row_ff + 8'd1 == cfg.sprite_height);
      last     = (rem_ff == LEN_W'(1)) || done;
      px = cfg.mode_flags[MODE_FLIP_X] ? cfg.sprite_width - 8'd1 - col_ff : col_ff;
      py = cfg.mode_flags[MODE_FLIP_Y] ? cfg.sprite_height - 8'd1 - row_ff : row_ff;

      busy_in = busy_ff;
      col_in  = col_ff;
      row_in  = row_ff;
      rem_in  = rem_ff;
      if (pop) begin
         busy_in = 1'b1;
         rem_in  = pop_data.length;
         if (col_ff >= cfg.sprite_width || row_ff >= cfg.sprite_height) begin
            col_in = '0;
            row_in = '0;
         end
      end else if (step) begin
         rem_in  = rem_ff - 1'b1;
         busy_in = !last;
         col_in  = col_wrap ? '0 : col_ff + 8'd1;
         if (done) begin
            row_in = '0;
         end else if (col_wrap) begin
            row_in = row_ff + 8'd1;
         end
      end

      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end

      rsp_ch.valid        = out_valid_ff;
      rsp_ch.pixel_x      = out_x_ff;
      rsp_ch.pixel_y      = out_y_ff;
      rsp_ch.pixel_color  = out_color_ff;
      rsp_ch.last_of_run  = out_last_ff;
      rsp_ch.end_of_image = out_end_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         col_ff       <= '0;
         row_ff       <= '0;
         rem_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         rem_ff       <= rem_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cmd_ff <= pop_data;
      end
      if (emit) begin
         out_x_ff     <= cfg.origin_x + px;
         out_y_ff     <= cfg.origin_y + py;
         out_color_ff <= cmd_ff.color;
         out_last_ff  <= last;
         out_end_ff   <= done;
      end
   end

endmodule

// ----- hdl/rle_palette_sprite_decoder_core.sv -----
// Top level of the run-length palette sprite decoder.
//
// Each request transaction carries one run byte: the colour value sits in the top
// two or three bits and the run length in the rest. The block expands the run into
// pixel response transactions in raster order over the configured sprite, each with
// screen coordinates, an RGB565 palette colour and last-of-run and end-of-image flags.
// Configuration registers are written through the csr channel, which is always ready;
// the user must write them only while the block is idle; the block does not enforce it.
// The expander loads a run only when idle and then steps through its pixels in turn,
// counted down by the remaining-length counter of the back end. The first pixel of a run
// passes the run queue, the run register of the back end and the response register
// before it appears on the response port. Transparent pixels are stepped like the
// others but give no response. Runs with zero length, an empty sprite or a placement
// past the screen edge are dropped in the front end at once.
// Reset restores the register defaults, empties the two-entry run queue and sets
// the position counters to the top-left corner.
// When the receiver stalls, the current pixel holds on the response port and the
// expansion of opaque pixels pauses; the queue keeps accepting runs until it is full.
module rle_palette_sprite_decoder_core #(
   parameter int PALETTE_ENTRIES = 8
) (
   input logic        clock,
   input logic        reset,
   rpsd_req_if.sink   req_ch,
   rpsd_rsp_if.source rsp_ch,
   rpsd_csr_if.sink   csr_ch
);
   import rpsd_pkg::*;

   cfg_type            cfg;
   logic [COLOR_W-1:0] palette [PALETTE_ENTRIES];
   queue_status_type   q_status;
   logic               push;
   cmd_type            push_data;
   logic               pop;
   cmd_type            pop_data;

   rpsd_csr #(.PALETTE_ENTRIES(PALETTE_ENTRIES)) u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_ch  (csr_ch),
      .cfg     (cfg),
      .palette (palette)
   );

   rpsd_front #(.PALETTE_ENTRIES(PALETTE_ENTRIES)) u_front (
      .req_ch    (req_ch),
      .cfg       (cfg),
      .palette   (palette),
      .q_status  (q_status),
      .push      (push),
      .push_data (push_data)
   );

   rpsd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .q_status  (q_status)
   );

   rpsd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .q_status (q_status),
      .pop_data (pop_data),
      .pop      (pop),
      .rsp_ch   (rsp_ch)
   );

endmodule
